/* hdl/jfe_pkg.sv */
// ----------------------------------------------------------------------------
// jfe_pkg
// shared constants, codes and types of the json field extractor
// ----------------------------------------------------------------------------
package jfe_pkg;

  localparam int MAX_KEY_BYTES = 16;
  localparam int WIN_DEPTH     = MAX_KEY_BYTES + 2;
  localparam int SEEN_W        = $clog2(WIN_DEPTH + 1);
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int MAX_RES       = 3;
  localparam int CNT_W         = $clog2(MAX_RES + 1);
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = $clog2(Q_DEPTH);

  localparam int CFG_DW        = 64;
  localparam int CFG_AW        = 5;
  localparam int REG_IDX_W     = 2;

  localparam logic [REG_IDX_W-1:0] REG_KEY_LO  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HI  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LEN = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MODE    = 2'd3;

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_STRING = 3'd2;
  localparam logic [2:0] PH_INT    = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_STR_END = 2'd1;
  localparam logic [1:0] KIND_INT     = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  // (2^63 - d) / 10 for digits zero to eight, one less for nine
  localparam logic [63:0] MAG_DIV10 = 64'd922337203685477580;

  typedef struct packed {
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  key_len;
    logic        extract_int;
  } jfe_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]           n;
    logic [MAX_RES-1:0][1:0]    kind;
    logic [MAX_RES-1:0][7:0]    data;
    logic [63:0]                number;
  } jfe_group_t;

  function automatic logic [63:0] int_of(input logic [63:0] mag, input logic neg);
    logic [63:0] v;
    if (neg) begin
      v = 64'd0 - mag;
    end else if (mag[63]) begin
      v = MAG_LIMIT - 64'd1;
    end else begin
      v = mag;
    end
    return v;
  endfunction

endpackage

/* hdl/jfe_front.sv */
// ----------------------------------------------------------------------------
// jfe_front
// takes text bytes, matches the quoted key and decodes the value into
// groups of up to three results per byte
// ----------------------------------------------------------------------------
module jfe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jfe_pkg::jfe_cfg_t    cfg,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 push,
  output jfe_pkg::jfe_group_t  push_group
);

  logic [jfe_pkg::WIN_DEPTH-1:0][7:0]     win_r, win_nxt, win_new;
  logic [jfe_pkg::SEEN_W-1:0]             seen_r, seen_nxt, seen_new;
  logic [2:0]                             ph_r, ph_nxt, ph1;
  logic                                   bs_r, bs_nxt, bs1;
  logic [63:0]                            mag_r, mag_nxt, mag1;
  logic                                   neg_r, neg_nxt, neg1;

  logic [127:0]                           key_all;
  logic [jfe_pkg::MAX_KEY_BYTES-1:0][7:0] key_chars;
  logic [jfe_pkg::KEY_IDX_W-1:0]          klen, eff_len;
  logic [jfe_pkg::MAX_KEY_BYTES:0]        match_vec;
  logic                                   window_hit;

  logic                                   accept, fin, is_digit, is_esc;
  logic [3:0]                             digit;
  logic [7:0]                             esc_char;
  logic [63:0]                            mag_x10, mag_lim, mag_acc;
  jfe_pkg::jfe_group_t                    g;
  logic [jfe_pkg::CNT_W-1:0]              cnt;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign fin      = (in_byte == jfe_pkg::CH_NUL) || in_last;

  // key characters and effective key length
  assign key_all = {cfg.key_hi, cfg.key_lo};

  always_comb begin
    for (int i = 0; i < jfe_pkg::MAX_KEY_BYTES; i++) begin
      key_chars[i] = key_all[8*i +: 8];
    end
    klen = (cfg.key_len > 5'(jfe_pkg::MAX_KEY_BYTES)) ?
           jfe_pkg::KEY_IDX_W'(jfe_pkg::MAX_KEY_BYTES) : jfe_pkg::KEY_IDX_W'(cfg.key_len);
    eff_len = klen;
    for (int i = jfe_pkg::MAX_KEY_BYTES - 1; i >= 0; i--) begin
      if ((jfe_pkg::KEY_IDX_W'(i) < klen) && (key_chars[i] == jfe_pkg::CH_NUL)) begin
        eff_len = jfe_pkg::KEY_IDX_W'(i);
      end
    end
  end

  // window after shifting in the current byte
  always_comb begin
    win_new[0] = in_byte;
    for (int k = 1; k < jfe_pkg::WIN_DEPTH; k++) begin
      win_new[k] = win_r[k-1];
    end
    seen_new = (seen_r == jfe_pkg::SEEN_W'(jfe_pkg::WIN_DEPTH)) ? seen_r :
               seen_r + jfe_pkg::SEEN_W'(1);
  end

  // one parallel compare per possible key length
  always_comb begin
    for (int l = 0; l <= jfe_pkg::MAX_KEY_BYTES; l++) begin
      match_vec[l] = (seen_new >= jfe_pkg::SEEN_W'(l + 2)) &&
                     (win_new[0] == jfe_pkg::CH_QUOTE) &&
                     (win_new[l+1] == jfe_pkg::CH_QUOTE);
      for (int i = 0; i < jfe_pkg::MAX_KEY_BYTES; i++) begin
        if (i < l) begin
          if (win_new[l-i] != key_chars[i]) begin
            match_vec[l] = 1'b0;
          end
        end
      end
    end
  end

  assign window_hit = match_vec[eff_len];

  // digit accumulate with saturation
  assign is_digit = (in_byte >= jfe_pkg::CH_ZERO) && (in_byte <= jfe_pkg::CH_NINE);
  assign digit    = 4'(in_byte - jfe_pkg::CH_ZERO);
  assign mag_x10  = (mag_r << 3) + (mag_r << 1);
  assign mag_lim  = jfe_pkg::MAG_DIV10 - ((digit == 4'd9) ? 64'd1 : 64'd0);
  assign mag_acc  = (mag_r > mag_lim) ? jfe_pkg::MAG_LIMIT : mag_x10 + 64'(digit);

  // escape decode
  always_comb begin
    is_esc   = 1'b1;
    esc_char = in_byte;
    case (in_byte)
      jfe_pkg::CH_QUOTE:  esc_char = jfe_pkg::CH_QUOTE;
      jfe_pkg::CH_BSLASH: esc_char = jfe_pkg::CH_BSLASH;
      jfe_pkg::CH_SLASH:  esc_char = jfe_pkg::CH_SLASH;
      jfe_pkg::CH_N:      esc_char = jfe_pkg::CH_LF;
      jfe_pkg::CH_R:      esc_char = jfe_pkg::CH_CR;
      jfe_pkg::CH_T:      esc_char = jfe_pkg::CH_TAB;
      default:            is_esc   = 1'b0;
    endcase
  end

  always_comb begin
    win_nxt  = win_r;
    seen_nxt = seen_r;
    ph1      = ph_r;
    bs1      = bs_r;
    mag1     = mag_r;
    neg1     = neg_r;
    g        = '0;
    cnt      = '0;

    if (in_byte != jfe_pkg::CH_NUL) begin
      case (ph_r)
        jfe_pkg::PH_SEARCH: begin
          win_nxt  = win_new;
          seen_nxt = seen_new;
          if (window_hit) begin
            ph1 = jfe_pkg::PH_SKIP;
          end
        end
        jfe_pkg::PH_SKIP: begin
          if ((in_byte != jfe_pkg::CH_SPACE) && (in_byte != jfe_pkg::CH_COLON)) begin
            if (!cfg.extract_int) begin
              if (in_byte == jfe_pkg::CH_QUOTE) begin
                ph1 = jfe_pkg::PH_STRING;
              end else begin
                g.kind[cnt] = jfe_pkg::KIND_NONE;
                g.number    = '1;
                cnt         = cnt + 1'b1;
                ph1         = jfe_pkg::PH_DONE;
              end
            end else if (in_byte == jfe_pkg::CH_MINUS) begin
              neg1 = 1'b1;
              mag1 = '0;
              ph1  = jfe_pkg::PH_INT;
            end else if (is_digit) begin
              mag1 = 64'(digit);
              ph1  = jfe_pkg::PH_INT;
            end else begin
              g.kind[cnt] = jfe_pkg::KIND_NONE;
              g.number    = '1;
              cnt         = cnt + 1'b1;
              ph1         = jfe_pkg::PH_DONE;
            end
          end
        end
        jfe_pkg::PH_STRING: begin
          if (bs_r) begin
            bs1         = 1'b0;
            g.kind[cnt] = jfe_pkg::KIND_BYTE;
            g.data[cnt] = is_esc ? esc_char : jfe_pkg::CH_BSLASH;
            cnt         = cnt + 1'b1;
          end
          if (!(bs_r && is_esc)) begin
            if (in_byte == jfe_pkg::CH_QUOTE) begin
              g.kind[cnt] = jfe_pkg::KIND_STR_END;
              cnt         = cnt + 1'b1;
              ph1         = jfe_pkg::PH_DONE;
            end else if (in_byte == jfe_pkg::CH_BSLASH) begin
              bs1 = 1'b1;
            end else begin
              g.kind[cnt] = jfe_pkg::KIND_BYTE;
              g.data[cnt] = in_byte;
              cnt         = cnt + 1'b1;
            end
          end
        end
        jfe_pkg::PH_INT: begin
          if (is_digit) begin
            mag1 = mag_acc;
          end else begin
            g.kind[cnt] = jfe_pkg::KIND_INT;
            g.number    = jfe_pkg::int_of(mag_r, neg_r);
            cnt         = cnt + 1'b1;
            ph1         = jfe_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    ph_nxt  = ph1;
    bs_nxt  = bs1;
    mag_nxt = mag1;
    neg_nxt = neg1;

    // end of text: flush what is open and re-arm
    if (fin) begin
      case (ph1)
        jfe_pkg::PH_SEARCH, jfe_pkg::PH_SKIP: begin
          g.kind[cnt] = jfe_pkg::KIND_NONE;
          g.number    = '1;
          cnt         = cnt + 1'b1;
        end
        jfe_pkg::PH_STRING: begin
          if (bs1) begin
            g.kind[cnt] = jfe_pkg::KIND_BYTE;
            g.data[cnt] = jfe_pkg::CH_BSLASH;
            cnt         = cnt + 1'b1;
          end
          g.kind[cnt] = jfe_pkg::KIND_STR_END;
          cnt         = cnt + 1'b1;
        end
        jfe_pkg::PH_INT: begin
          g.kind[cnt] = jfe_pkg::KIND_INT;
          g.number    = jfe_pkg::int_of(mag1, neg1);
          cnt         = cnt + 1'b1;
        end
        default: begin
        end
      endcase
      win_nxt  = '0;
      seen_nxt = '0;
      ph_nxt   = jfe_pkg::PH_SEARCH;
      bs_nxt   = 1'b0;
      mag_nxt  = '0;
      neg_nxt  = 1'b0;
    end

    g.n = cnt;
  end

  assign push       = accept && (cnt != '0);
  assign push_group = g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      seen_r <= '0;
      ph_r   <= jfe_pkg::PH_SEARCH;
      bs_r   <= 1'b0;
      mag_r  <= '0;
      neg_r  <= 1'b0;
    end else if (accept) begin
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
      ph_r   <= ph_nxt;
      bs_r   <= bs_nxt;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
    end
  end

endmodule

/* hdl/jfe_queue.sv */
// ----------------------------------------------------------------------------
// jfe_queue
// short queue of result groups between the front and back parts
// ----------------------------------------------------------------------------
module jfe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jfe_pkg::jfe_group_t  push_group,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output jfe_pkg::jfe_group_t  head
);

  jfe_pkg::jfe_group_t       q_r [jfe_pkg::Q_DEPTH];
  logic [jfe_pkg::Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [jfe_pkg::Q_AW:0]    count_r, count_nxt;
  logic                      do_push, do_pop;

  assign full    = (count_r == (jfe_pkg::Q_AW + 1)'(jfe_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* hdl/jfe_back.sv */
// ----------------------------------------------------------------------------
// jfe_back
// walks the head group and presents one result per output transfer
// ----------------------------------------------------------------------------
module jfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 empty,
  input  jfe_pkg::jfe_group_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic [63:0]          out_number,
  output logic                 out_last
);

  logic [jfe_pkg::CNT_W-1:0] sub_r, sub_nxt;
  logic                      xfer;

  assign out_valid  = !empty;
  assign out_kind   = head.kind[sub_r];
  assign out_byte   = head.data[sub_r];
  assign out_number = ((out_kind == jfe_pkg::KIND_INT) || (out_kind == jfe_pkg::KIND_NONE)) ?
                      head.number : 64'd0;
  assign out_last   = (sub_r == head.n - 1'b1);
  assign xfer       = out_valid && out_ready;
  assign pop        = xfer && out_last;
  assign sub_nxt    = out_last ? '0 : sub_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
    end else if (xfer) begin
      sub_r <= sub_nxt;
    end
  end

endmodule

/* hdl/json_field_extractor.sv */
// ----------------------------------------------------------------------------
// json_field_extractor
// streaming json key/value extractor: finds the configured quoted key and
// returns the decoded string bytes or the parsed integer
//
//   channel  dir  ports        contents
//   in_      in   tdata[7:0]   text byte
//                 tlast        end of text
//   out_     out  tdata[71:0]  value byte, number
//                 tuser[1:0]   kind
//                 tlast        last result of its input byte
//   cfg_     in   apb 64-bit   key low, key high, key length, mode at 8*i
//
// one text byte per cycle while the result queue has room; each byte makes zero to three results
// results leave one per cycle while out_tready is high, a byte with several holds the out side as long
// in_tready drops only when the four-group result queue is full
// reset is synchronous and clears parser state and registers at once
// ----------------------------------------------------------------------------
module json_field_extractor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // text_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [71:0]                 out_tdata,  // value_byte, number
  output logic [1:0]                  out_tuser,  // kind
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [jfe_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [jfe_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [jfe_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  jfe_pkg::jfe_cfg_t                cfg_r;
  logic                             cfg_wr;
  logic [jfe_pkg::REG_IDX_W-1:0]    reg_idx;

  logic                             push, pop, q_full, q_empty;
  jfe_pkg::jfe_group_t              push_group, head;
  logic [7:0]                       res_byte;
  logic [63:0]                      res_number;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[jfe_pkg::CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        jfe_pkg::REG_KEY_LO:  cfg_r.key_lo      <= cfg_pwdata;
        jfe_pkg::REG_KEY_HI:  cfg_r.key_hi      <= cfg_pwdata;
        jfe_pkg::REG_KEY_LEN: cfg_r.key_len     <= cfg_pwdata[4:0];
        jfe_pkg::REG_MODE:    cfg_r.extract_int <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jfe_pkg::REG_KEY_LO:  cfg_prdata = cfg_r.key_lo;
      jfe_pkg::REG_KEY_HI:  cfg_prdata = cfg_r.key_hi;
      jfe_pkg::REG_KEY_LEN: cfg_prdata = 64'(cfg_r.key_len);
      jfe_pkg::REG_MODE:    cfg_prdata = 64'(cfg_r.extract_int);
      default:              cfg_prdata = '0;
    endcase
  end

  jfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .q_full     (q_full),
    .push       (push),
    .push_group (push_group)
  );

  jfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  jfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (res_byte),
    .out_number (res_number),
    .out_last   (out_tlast)
  );

  assign out_tdata = {res_number, res_byte};

endmodule

/* hdl/jfe_checker.sv */
// ----------------------------------------------------------------------------
// jfe_checker
// port-level checks on the result stream of the json field extractor
// ----------------------------------------------------------------------------
module jfe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // end, integer and not-found results close their run
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != jfe_pkg::KIND_BYTE) |-> out_tlast)
    else $error("terminal result not marked last");

  // not found carries minus one and no byte
  a_none_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == jfe_pkg::KIND_NONE) |->
      (out_tdata[71:8] == 64'hFFFF_FFFF_FFFF_FFFF) && (out_tdata[7:0] == 8'h00))
    else $error("not-found result has wrong payload");

  // byte and string-end results carry no number
  a_byte_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == jfe_pkg::KIND_BYTE) || (out_tuser == jfe_pkg::KIND_STR_END))
      |-> (out_tdata[71:8] == 64'd0))
    else $error("string result has nonzero number");

endmodule

bind json_field_extractor jfe_checker u_jfe_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for json_field_extractor: streams short json texts
// through the byte channel under random bursts and output stalls, predicts
// every result from its own copy of the parser state and checks each transfer
// on the result channel field by field
// ----------------------------------------------------------------------------
module tb;
  import jfe_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 16;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  value_byte;
    logic [63:0] number;
    logic        last_of_run;
  } extract_result_t;

  class extract_scoreboard;
    logic [63:0]     key_lo, key_hi;
    logic [4:0]      key_len;
    logic            int_mode;
    logic [7:0]      window [WIN_DEPTH];
    int unsigned     seen;
    logic [2:0]      phase;
    logic            in_escape;
    logic [63:0]     mag;
    logic            neg;
    extract_result_t pending[$];
    int              errors, n_bytes, n_results;

    function new();
      key_lo = '0;
      key_hi = '0;
      key_len = '0;
      int_mode = 1'b0;
      errors = 0;
      n_bytes = 0;
      n_results = 0;
      restart();
    endfunction

    function void restart();
      foreach (window[i]) window[i] = 8'd0;
      seen = 0;
      phase = PH_SEARCH;
      in_escape = 1'b0;
      mag = '0;
      neg = 1'b0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] v);
      case (idx)
        REG_KEY_LO:  key_lo = v;
        REG_KEY_HI:  key_hi = v;
        REG_KEY_LEN: key_len = v[4:0];
        default:     int_mode = v[0];
      endcase
    endfunction

    function void add(logic [1:0] k, logic [7:0] b, logic [63:0] n);
      extract_result_t r;
      r.kind = k;
      r.value_byte = b;
      r.number = n;
      r.last_of_run = 1'b0;
      pending.push_back(r);
    endfunction

    function logic [7:0] key_char(int i);
      if (i < 8) return key_lo[8*i +: 8];
      return key_hi[8*(i-8) +: 8];
    endfunction

    function bit key_in_window();
      int n;
      n = (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len);
      for (int i = 0; i < n; i++) begin
        if (key_char(i) == 8'd0) begin
          n = i;
          break;
        end
      end
      if (seen < n + 2) return 1'b0;
      if (window[0] != CH_QUOTE || window[n+1] != CH_QUOTE) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (window[n-i] != key_char(i)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void add_integer();
      logic [63:0] v;
      if (neg) begin
        v = (mag >= MAG_LIMIT) ? MAG_LIMIT : 64'd0 - mag;
      end else begin
        v = (mag >= MAG_LIMIT) ? MAG_LIMIT - 64'd1 : mag;
      end
      add(KIND_INT, 8'd0, v);
    endfunction

    function void string_byte(logic [7:0] b);
      if (in_escape) begin
        in_escape = 1'b0;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            add(KIND_BYTE, b, '0);
            return;
          end
          CH_N: begin
            add(KIND_BYTE, CH_LF, '0);
            return;
          end
          CH_R: begin
            add(KIND_BYTE, CH_CR, '0);
            return;
          end
          CH_T: begin
            add(KIND_BYTE, CH_TAB, '0);
            return;
          end
          default: add(KIND_BYTE, CH_BSLASH, '0);
        endcase
      end
      if (b == CH_QUOTE) begin
        add(KIND_STR_END, 8'd0, '0);
        phase = PH_DONE;
      end else if (b == CH_BSLASH) begin
        in_escape = 1'b1;
      end else begin
        add(KIND_BYTE, b, '0);
      end
    endfunction

    function void consume(logic [7:0] b);
      logic [63:0] d;
      logic        digit;
      digit = (b >= CH_ZERO) && (b <= CH_NINE);
      d = {56'd0, b - CH_ZERO};
      case (phase)
        PH_SEARCH: begin
          for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
          window[0] = b;
          if (seen < WIN_DEPTH) seen++;
          if (key_in_window()) phase = PH_SKIP;
        end
        PH_SKIP: begin
          if (b != CH_SPACE && b != CH_COLON) begin
            if (!int_mode) begin
              if (b == CH_QUOTE) begin
                phase = PH_STRING;
              end else begin
                add(KIND_NONE, 8'd0, '1);
                phase = PH_DONE;
              end
            end else if (b == CH_MINUS) begin
              neg = 1'b1;
              mag = '0;
              phase = PH_INT;
            end else if (digit) begin
              mag = d;
              phase = PH_INT;
            end else begin
              add(KIND_NONE, 8'd0, '1);
              phase = PH_DONE;
            end
          end
        end
        PH_STRING: string_byte(b);
        PH_INT: begin
          if (digit) begin
            if (mag > (MAG_LIMIT - d) / 64'd10) mag = MAG_LIMIT;
            else mag = mag * 64'd10 + d;
          end else begin
            add_integer();
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void finish_text();
      case (phase)
        PH_SEARCH, PH_SKIP: add(KIND_NONE, 8'd0, '1);
        PH_STRING: begin
          if (in_escape) add(KIND_BYTE, CH_BSLASH, '0);
          add(KIND_STR_END, 8'd0, '0);
        end
        PH_INT: add_integer();
        default: ;
      endcase
      restart();
    endfunction

    function void take_text_byte(logic [7:0] b, logic end_flag);
      int before_cnt;
      extract_result_t r;
      before_cnt = pending.size();
      n_bytes++;
      if (b == CH_NUL) begin
        finish_text();
      end else begin
        consume(b);
        if (end_flag) finish_text();
      end
      if (pending.size() > before_cnt) begin
        r = pending.pop_back();
        r.last_of_run = 1'b1;
        pending.push_back(r);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] vb, logic [63:0] num,
                               logic lst);
      extract_result_t e;
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        $error("unexpected result: kind %0d value_byte %02h number %0d", kind, vb,
               $signed(num));
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) begin
        errors++;
        $error("kind: expected %0d, got %0d", e.kind, kind);
      end
      if (vb !== e.value_byte) begin
        errors++;
        $error("value_byte: expected %02h, got %02h", e.value_byte, vb);
      end
      if (num !== e.number) begin
        errors++;
        $error("number: expected %0d, got %0d", $signed(e.number), $signed(num));
      end
      if (lst !== e.last_of_run) begin
        errors++;
        $error("last_of_run: expected %0d, got %0d", e.last_of_run, lst);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'd0;    // text_byte
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [71:0]          out_tdata;          // value_byte, number
  logic [1:0]           out_tuser;          // kind
  logic                 out_tlast;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr = '0;
  logic [CFG_DW-1:0]    cfg_pwdata = '0;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  extract_scoreboard extract_sb = new();

  int          burst_left = 0;
  int          cycles = 0;
  int          settings = 0;
  logic [7:0]  stall_cnt = 8'd0;
  logic [7:0]  text_q[$];
  logic [7:0]  cur_key [MAX_KEY_BYTES];
  int          cur_len;
  logic        cur_mode;

  json_field_extractor uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 8'd1;
    case (stall_cnt[7:6])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= (stall_cnt[1:0] == 2'd0);
      default: out_tready <= (stall_cnt[3:0] < 4'd5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) extract_sb.take_text_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        extract_sb.check_result(out_tuser, out_tdata[7:0], out_tdata[71:8], out_tlast);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic end_flag);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= end_flag;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  task automatic send_str(input string s, input logic end_on_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_on_last && (i == s.len() - 1));
  endtask

  // stop sending and let the block drain before touching registers
  task automatic settle();
    if (burst_left != 0) in_tvalid <= 1'b0;
    burst_left = 0;
    while (extract_sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // select stays high across back-to-back writes
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    extract_sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len, input logic mode);
    settle();
    cfg_write(REG_KEY_LO, lo);
    cfg_write(REG_KEY_HI, hi);
    cfg_write(REG_KEY_LEN, {59'd0, len});
    cfg_write(REG_MODE, {63'd0, mode});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] filler();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return 8'h2C;
      default: return 8'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] escape_char();
    case ($urandom_range(0, 6))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return CH_N;
      4:       return CH_R;
      5:       return CH_T;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // one random text: mostly a well-formed key/value pair, some noise,
  // some with a damaged key and some with the wrong kind of value
  task automatic make_text();
    int          shape, n, bad;
    logic [7:0]  c;
    text_q.delete();
    shape = $urandom_range(0, 9);
    if (shape == 7) begin
      n = $urandom_range(3, 10);
      repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    bad = (shape == 8) ? $urandom_range(0, cur_len - 1) : -1;
    text_q.push_back(8'h7B);
    repeat ($urandom_range(0, 3)) text_q.push_back(filler());
    text_q.push_back(CH_QUOTE);
    for (int i = 0; i < cur_len; i++) text_q.push_back(cur_key[i] ^ {7'd0, i == bad});
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 3)) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_COLON);
    if (shape == 9) begin
      text_q.push_back(cur_mode ? CH_QUOTE : 8'h78);
    end else if (!cur_mode) begin
      text_q.push_back(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(escape_char());
        end else begin
          c = 8'($urandom_range(1, 255));
          if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
          text_q.push_back(c);
        end
      end
      if ($urandom_range(0, 5) != 0) text_q.push_back(CH_QUOTE);
    end else begin
      if ($urandom_range(0, 2) == 0) text_q.push_back(CH_MINUS);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 21) : $urandom_range(0, 6);
      repeat (n) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 3) != 0) text_q.push_back($urandom_range(0, 1) ? 8'h2C : 8'h7D);
    end
    repeat ($urandom_range(0, 2)) text_q.push_back(filler());
  endtask

  task automatic send_text();
    int ending;
    ending = $urandom_range(0, 7);
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], (ending < 5) && (i == text_q.size() - 1));
    if (ending == 5 || ending == 6) send_byte(CH_NUL, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [63:0] lo, hi;
    int          rand_bytes;
    rand_bytes = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // string mode: escapes, bytes after the value, missing key, wrong kind
    apply_setting(64'h6B, 64'd0, 5'd1, 1'b0);
    send_str("\"k\": \"\\\"\\\\\\/\\n\\r\\t\\q\\", 1'b1);
    send_str("\"k\"\"", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_str("\"x", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_NUL, 1'b1);
    send_str("\"k\"x", 1'b1);
    send_str("\"k\"", 1'b1);

    // integer mode: bare minus, saturation, wrong kind, number at end
    apply_setting(64'h6B, 64'd0, 5'd1, 1'b1);
    send_str("\"k\":-", 1'b1);
    send_str("\"k\":-9223372036854775809,", 1'b1);
    send_str("\"k\":a", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_str("\"k\": 12", 1'b1);
    send_str("\"k\":", 1'b0);

    // mode switched before the value starts
    apply_setting(64'h6B, 64'd0, 5'd1, 1'b0);
    send_str("\"hi\"", 1'b1);

    // oversized key length with all-ones key
    apply_setting('1, '1, 5'd31, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    repeat (MAX_KEY_BYTES) send_byte(8'hFF, 1'b0);
    send_str("\":\"v\"", 1'b1);

    // zero character inside the key
    apply_setting(64'h0000_0000_0061_006B, 64'd0, 5'd3, 1'b1);
    send_str("\"k\":7", 1'b1);

    // empty key
    apply_setting(64'd0, 64'd0, 5'd0, 1'b0);
    send_str("x\"\"\"e\"", 1'b1);

    while (rand_bytes < RANDOM_BYTES) begin
      cur_len = ($urandom_range(0, 5) == 0) ? MAX_KEY_BYTES : $urandom_range(1, 4);
      cur_mode = 1'($urandom_range(0, 1));
      lo = '0;
      hi = '0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        cur_key[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'(8'h61 + $urandom_range(0, 25));
        if (i < 8) lo[8*i +: 8] = cur_key[i];
        else hi[8*(i-8) +: 8] = cur_key[i];
      end
      apply_setting(lo, hi, 5'(cur_len), cur_mode);
      repeat (2) begin
        make_text();
        rand_bytes += text_q.size();
        send_text();
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (extract_sb.pending.size() != 0) begin
      extract_sb.errors++;
      $error("%0d expected results never arrived", extract_sb.pending.size());
    end
    $display("%0d text bytes sent under %0d key settings, %0d results checked",
             extract_sb.n_bytes, settings, extract_sb.n_results);
    if (extract_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
